// ----- rtl/csu_pkg.sv -----
// Shared types and fixed-point constants for the cosine and sine unit.
`timescale 1ns / 1ps
package csu_pkg;

	// Angle constants in Q.32 radians; 2*pi needs 35 bits.
	localparam int C_W = 35;
	localparam int R_W = 33;
	localparam logic [C_W-1:0] Q32_PIO2 = 35'd6746518852;
	localparam logic [C_W-1:0] Q32_PI = 35'd13493037705;
	localparam logic [C_W-1:0] Q32_2PI_HI = 35'd26986075409;
	// Low part of 2*pi in units of 2^-64.
	localparam logic [27:0] Q64_2PI_LO = 28'd189141414;
	// floor(2^66 / 2pi_hi): quotient estimate for the reduction.
	localparam logic [31:0] RECIP = 32'((68'd1 << 66) / 68'(Q32_2PI_HI));

	// Taylor coefficients 1/n! in Q.60.
	localparam logic [63:0] Q60_ONE = 64'd1 << 60;
	localparam logic [63:0] K2 = Q60_ONE / 64'd2;
	localparam logic [63:0] K4 = (Q60_ONE + 64'd12) / 64'd24;
	localparam logic [63:0] K6 = (Q60_ONE + 64'd360) / 64'd720;
	localparam logic [63:0] K8 = (Q60_ONE + 64'd20160) / 64'd40320;
	localparam logic [63:0] K10 = (Q60_ONE + 64'd1814400) / 64'd3628800;
	localparam logic [63:0] K12 = (Q60_ONE + 64'd239500800) / 64'd479001600;

	localparam int HORNER_STEPS = 6;
	localparam logic signed [63:0] HORNER_COEF [HORNER_STEPS] = '{
		-$signed(K10), $signed(K8), -$signed(K6), $signed(K4), -$signed(K2), $signed(Q60_ONE)
	};

	// Pipeline depths of the parts.
	localparam int RED_LAT = 9;
	localparam int MUL_LAT = 3;
	localparam int STEP_LAT = 5;
	localparam int OUT_LAT = 3;

	// Folded angle leaving the reduction.
	typedef struct packed {
		logic valid;
		logic neg;
		logic [R_W-1:0] r;
	} csu_fold_t;

	// Word travelling through the Horner chain.
	typedef struct packed {
		logic valid;
		logic neg;
		logic [63:0] x2;
		logic signed [63:0] acc;
	} csu_horner_t;

endpackage

// ----- rtl/csu_mul_q60.sv -----
// Pipelined 64x64 multiplier returning the product shifted right by 60, rounded.
`timescale 1ns / 1ps
module csu_mul_q60 (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [64:0] mid_s2;
	logic [63:0] lo_s2, hi_s2;
	logic [127:0] full;
	logic [63:0] p_s3;

	// Add the rounding half of bit 60 in the final sum.
	assign full = {hi_s2, lo_s2} + {31'b0, mid_s2, 32'b0} + (128'd1 << 59);

	always_ff @(posedge clk) begin
		ll_s1 <= a[31:0] * b[31:0];
		lh_s1 <= a[31:0] * b[63:32];
		hl_s1 <= a[63:32] * b[31:0];
		hh_s1 <= a[63:32] * b[63:32];
		mid_s2 <= {1'b0, lh_s1} + {1'b0, hl_s1};
		lo_s2 <= ll_s1;
		hi_s2 <= hh_s1;
		p_s3 <= full[123:60];
	end

	assign p = p_s3;

endmodule

// ----- rtl/csu_reduce.sv -----
// Angle preparation: sine offset, absolute value, reduction modulo 2*pi and fold.
`timescale 1ns / 1ps
module csu_reduce #(
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [31:0] angle,
	input  logic               operation,
	output csu_pkg::csu_fold_t fold
);
	import csu_pkg::*;

	localparam int SH = 32 - ANGLE_FRAC_BITS;
	localparam int MW = 65 - ANGLE_FRAC_BITS;
	localparam int AW = MW + 1;
	localparam int NW = MW - 34;
	localparam int PW = MW + 12;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic signed [AW-1:0] ang_w;
	logic signed [AW-1:0] a_s1;
	logic [MW-1:0] mag_s2, mag_s3, mag_s4;
	logic [PW-1:0] prod_s3;
	logic [NW-1:0] nest;
	logic [NW+C_W-1:0] nc_full;
	logic [NW-1:0] nest_s4, n_s5;
	logic [MW-1:0] nc_s4;
	logic [MW:0] d0, d1;
	logic [C_W-1:0] rem_s5, rem_s6;
	logic [NW+31:0] lo_sum;
	logic [NW-1:0] lo_s6;
	logic [C_W:0] t0, t1;
	logic [C_W-1:0] r_s7, r_s8;
	logic [R_W-1:0] r_s9;
	logic neg_s9;

	assign ang_w = {{2{angle[31]}}, angle, {SH{1'b0}}};

	// Quotient estimate is low by at most one; fix it with one compare.
	assign nest = prod_s3[PW-1:46];
	assign nc_full = nest * Q32_2PI_HI;
	assign d0 = {1'b0, mag_s4} - {1'b0, nc_s4};
	assign d1 = d0 - AW'(Q32_2PI_HI);

	assign lo_sum = n_s5 * Q64_2PI_LO + (NW + 32)'(32'h8000_0000);

	// Low-part correction may go below zero: wrap by one period.
	assign t0 = {1'b0, rem_s6} - (C_W + 1)'(lo_s6);
	assign t1 = t0 + (C_W + 1)'(Q32_2PI_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= operation ? ang_w - $signed(AW'(Q32_PIO2)) : ang_w;
		mag_s2 <= a_s1[AW-1] ? MW'(-a_s1) : MW'(a_s1);
		prod_s3 <= mag_s2[MW-1:20] * RECIP;
		mag_s3 <= mag_s2;
		nest_s4 <= nest;
		nc_s4 <= nc_full[MW-1:0];
		mag_s4 <= mag_s3;
		if (!d1[MW]) begin
			rem_s5 <= d1[C_W-1:0];
			n_s5 <= nest_s4 + NW'(1);
		end else begin
			rem_s5 <= d0[C_W-1:0];
			n_s5 <= nest_s4;
		end
		lo_s6 <= lo_sum[NW+31:32];
		rem_s6 <= rem_s5;
		r_s7 <= t0[C_W] ? t1[C_W-1:0] : t0[C_W-1:0];
		r_s8 <= (r_s7 > Q32_PI) ? Q32_2PI_HI - r_s7 : r_s7;
		if (r_s8 > Q32_PIO2) begin
			r_s9 <= R_W'(Q32_PI - r_s8);
			neg_s9 <= 1'b1;
		end else begin
			r_s9 <= R_W'(r_s8);
			neg_s9 <= 1'b0;
		end
	end

	assign fold.valid = vld_s9;
	assign fold.neg = neg_s9;
	assign fold.r = r_s9;

endmodule

// ----- rtl/csu_horner_step.sv -----
// One Horner step: acc = COEF + x2 * acc in Q.60, over five pipeline stages.
`timescale 1ns / 1ps
module csu_horner_step #(
	parameter logic signed [63:0] COEF = 64'sd0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csu_pkg::csu_horner_t word_in,
	output csu_pkg::csu_horner_t word_out
);
	import csu_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [63:0] mag_s1;
	logic sgn_s1, sgn_s2, sgn_s3, sgn_s4;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [63:0] x2_s1, x2_s2, x2_s3, x2_s4, x2_s5;
	logic [63:0] prod;
	logic signed [63:0] acc_s5;

	csu_mul_q60 u_mul (
		.clk (clk),
		.a   (x2_s1),
		.b   (mag_s1),
		.p   (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= word_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Multiply the magnitude, then restore the sign in the final add.
	always_ff @(posedge clk) begin
		mag_s1 <= word_in.acc[63] ? 64'(-word_in.acc) : 64'(word_in.acc);
		sgn_s1 <= word_in.acc[63];
		neg_s1 <= word_in.neg;
		x2_s1 <= word_in.x2;
		sgn_s2 <= sgn_s1;
		sgn_s3 <= sgn_s2;
		sgn_s4 <= sgn_s3;
		neg_s2 <= neg_s1;
		neg_s3 <= neg_s2;
		neg_s4 <= neg_s3;
		neg_s5 <= neg_s4;
		x2_s2 <= x2_s1;
		x2_s3 <= x2_s2;
		x2_s4 <= x2_s3;
		x2_s5 <= x2_s4;
		acc_s5 <= COEF + (sgn_s4 ? -$signed(prod) : $signed(prod));
	end

	assign word_out.valid = vld_s5;
	assign word_out.neg = neg_s5;
	assign word_out.x2 = x2_s5;
	assign word_out.acc = acc_s5;

endmodule

// ----- rtl/cosine_sine_unit.sv -----
// Top level of the fixed-point cosine and sine unit.
//
// Input channel: an angle word (signed radians, ANGLE_FRAC_BITS fraction bits)
// and an operation bit (0 cosine, 1 sine) are taken at each rising edge with
// start high and busy low. busy stays low: a new word may enter every cycle.
// Result channel: value (signed, OUT_FRAC_BITS fraction bits, within +/-1)
// is shown for one cycle with done high; the receiver cannot stall it.
// Each accepted word passes through reduction and folding, squaring of the
// angle, the six Horner steps, then rounding and sign. Throughput is one
// word per cycle, set by the fully pipelined multipliers (four 32x32 partial
// products per 64-bit product, summed over two further stages).
// Words leave in the order they entered.
// Reset clears all valid bits at once; data registers keep no reset, and no
// done strobe appears until a word has passed through the whole pipeline.
`timescale 1ns / 1ps
module cosine_sine_unit #(
	parameter int ANGLE_FRAC_BITS = 24,
	parameter int OUT_FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] angle,
	input  logic               operation,
	output logic signed [31:0] value,
	output logic               done
);
	import csu_pkg::*;

	localparam int SH_OUT = 60 - OUT_FRAC_BITS;
	localparam int VW = 64 - SH_OUT;
	localparam int LATENCY = RED_LAT + MUL_LAT + HORNER_STEPS * STEP_LAT + OUT_LAT;
	localparam logic [63:0] HALF = 64'd1 << (SH_OUT - 1);
	localparam logic [31:0] ONE_OUT = 32'd1 << OUT_FRAC_BITS;

	csu_fold_t fold_w;
	logic [63:0] r60;
	logic [63:0] x2;
	logic sq_vld_s1, sq_vld_s2, sq_vld_s3;
	logic sq_neg_s1, sq_neg_s2, sq_neg_s3;
	csu_horner_t hw [HORNER_STEPS+1];

	logic signed [63:0] acc;
	logic o_vld_s1, o_vld_s2, o_vld_s3;
	logic o_neg_s1, o_neg_s2;
	logic [63:0] o_mag_s1;
	logic [63:0] rsum;
	logic [VW-1:0] o_v_s2;
	logic [VW-1:0] vs;
	logic [31:0] mag32;
	logic signed [31:0] val_s3;

	assign busy = 1'b0;

	csu_reduce #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.angle     (angle),
		.operation (operation),
		.fold      (fold_w)
	);

	assign r60 = {3'b0, fold_w.r, 28'b0};

	csu_mul_q60 u_square (
		.clk (clk),
		.a   (r60),
		.b   (r60),
		.p   (x2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1 <= 1'b0;
			sq_vld_s2 <= 1'b0;
			sq_vld_s3 <= 1'b0;
			o_vld_s1 <= 1'b0;
			o_vld_s2 <= 1'b0;
			o_vld_s3 <= 1'b0;
		end else begin
			sq_vld_s1 <= fold_w.valid;
			sq_vld_s2 <= sq_vld_s1;
			sq_vld_s3 <= sq_vld_s2;
			o_vld_s1 <= hw[HORNER_STEPS].valid;
			o_vld_s2 <= o_vld_s1;
			o_vld_s3 <= o_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_neg_s1 <= fold_w.neg;
		sq_neg_s2 <= sq_neg_s1;
		sq_neg_s3 <= sq_neg_s2;
	end

	// Horner chain starts from the x^12 coefficient.
	assign hw[0].valid = sq_vld_s3;
	assign hw[0].neg = sq_neg_s3;
	assign hw[0].x2 = x2;
	assign hw[0].acc = $signed(K12);

	for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
		csu_horner_step #(
			.COEF (HORNER_COEF[i])
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.word_in  (hw[i]),
			.word_out (hw[i+1])
		);
	end

	// Round the magnitude, clamp to one, then apply the sign.
	assign acc = hw[HORNER_STEPS].acc;
	assign rsum = o_mag_s1 + HALF;
	assign vs = (o_v_s2 > VW'(ONE_OUT)) ? VW'(ONE_OUT) : o_v_s2;
	assign mag32 = 32'(vs);

	always_ff @(posedge clk) begin
		o_neg_s1 <= hw[HORNER_STEPS].neg ^ acc[63];
		o_mag_s1 <= acc[63] ? 64'(-acc) : 64'(acc);
		o_neg_s2 <= o_neg_s1;
		o_v_s2 <= rsum[63:SH_OUT];
		val_s3 <= o_neg_s2 ? $signed(-mag32) : $signed(mag32);
	end

	assign value = val_s3;
	assign done = o_vld_s3;

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word did not produce a result on time");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without a matching accepted word");

	a_zero_cos: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && angle == 32'sd0 && !operation |->
			##LATENCY (value == $signed(ONE_OUT)))
		else $error("cosine of zero is not exactly one");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		fold_w.valid |-> (35'(fold_w.r) <= Q32_PIO2))
		else $error("folded angle above pi/2");

endmodule

// ----- test/cosine_sine_checker.sv -----
// Checker for the cosine and sine unit: predicts each result and compares it.
`timescale 1ns / 1ps
module cosine_sine_checker #(
	parameter int ANGLE_FRAC_BITS = 24,
	parameter int OUT_FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] angle,
	input  logic               operation,
	input  logic signed [31:0] value,
	input  logic               done,
	output int                 errors,
	output int                 pending
);

	// Angles in Q.32 radians; 2*pi carries an extra low part in units of 2^-64.
	localparam logic signed [63:0] HALF_PI = 64'sd6746518852;
	localparam logic signed [63:0] PI = 64'sd13493037705;
	localparam logic signed [63:0] TWO_PI = 64'sd26986075409;
	localparam logic [63:0] TWO_PI_LO = 64'd189141414;

	// Taylor terms 1/n! in Q.60, rounded to nearest.
	localparam logic signed [63:0] ONE = 64'sd1 <<< 60;
	localparam logic signed [63:0] K2 = ONE / 64'sd2;
	localparam logic signed [63:0] K4 = (ONE + 64'sd12) / 64'sd24;
	localparam logic signed [63:0] K6 = (ONE + 64'sd360) / 64'sd720;
	localparam logic signed [63:0] K8 = (ONE + 64'sd20160) / 64'sd40320;
	localparam logic signed [63:0] K10 = (ONE + 64'sd1814400) / 64'sd3628800;
	localparam logic signed [63:0] K12 = (ONE + 64'sd239500800) / 64'sd479001600;

	typedef struct {
		logic signed [31:0] angle;
		logic               operation;
		logic signed [31:0] value;
	} trig_word_t;

	trig_word_t value_queue [$];
	trig_word_t head;
	int err_count = 0;

	assign errors = err_count;

	// Unsigned Q.60 product, rounded half up.
	function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << 59);
		return p[123:60];
	endfunction

	// Signed Q.60 times non-negative square, ties away from zero.
	function automatic logic signed [63:0] q60_scale(input logic [63:0] x2,
			input logic signed [63:0] acc);
		logic [63:0] m;
		logic [63:0] p;
		m = (acc < 0) ? -acc : acc;
		p = q60_mul(x2, m);
		return (acc < 0) ? -$signed(p) : $signed(p);
	endfunction

	function automatic logic signed [31:0] cos_sin_fixed(input logic signed [31:0] ang,
			input logic op);
		logic signed [63:0] a;
		logic signed [63:0] n;
		logic signed [63:0] acc;
		logic [63:0] lo;
		logic [63:0] r60;
		logic [63:0] x2;
		logic [63:0] mag;
		logic [63:0] v;
		logic [63:0] res;
		logic neg;
		neg = 1'b0;
		a = ang;
		a = a * (64'sd1 <<< (32 - ANGLE_FRAC_BITS));
		if (op)
			a = a - HALF_PI;
		if (a < 0)
			a = -a;
		if (a >= TWO_PI) begin
			n = a / TWO_PI;
			lo = ($unsigned(n) * TWO_PI_LO + (64'd1 << 31)) >> 32;
			a = a - n * TWO_PI - $signed(lo);
			if (a < 0)
				a = a + TWO_PI;
			if (a >= TWO_PI)
				a = a - TWO_PI;
		end
		// fold into [0, pi/2]
		if (a > PI)
			a = TWO_PI - a;
		if (a > HALF_PI) begin
			a = PI - a;
			neg = 1'b1;
		end
		r60 = $unsigned(a) << 28;
		x2 = q60_mul(r60, r60);
		acc = K12;
		acc = q60_scale(x2, acc) - K10;
		acc = q60_scale(x2, acc) + K8;
		acc = q60_scale(x2, acc) - K6;
		acc = q60_scale(x2, acc) + K4;
		acc = q60_scale(x2, acc) - K2;
		acc = q60_scale(x2, acc) + ONE;
		if (acc < 0) begin
			neg = !neg;
			mag = -acc;
		end else begin
			mag = acc;
		end
		v = (mag + (64'd1 << (60 - OUT_FRAC_BITS - 1))) >> (60 - OUT_FRAC_BITS);
		if (v > (64'd1 << OUT_FRAC_BITS))
			v = 64'd1 << OUT_FRAC_BITS;
		res = neg ? -v : v;
		return res[31:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// retire before taking the new word: a result never matches a word of the same edge
			if (done) begin
				if (value_queue.size() == 0) begin
					$error("value: no word outstanding, got %0d", value);
					err_count++;
				end else begin
					head = value_queue.pop_front();
					if (value !== head.value) begin
						$error("value: expected %0d, got %0d (angle %0d, operation %0b)",
							head.value, value, head.angle, head.operation);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				head.angle = angle;
				head.operation = operation;
				head.value = cos_sin_fixed(angle, operation);
				value_queue.push_back(head);
			end
			pending <= value_queue.size();
		end else begin
			pending <= 0;
		end
	end

endmodule

// ----- test/cosine_sine_unit_test.sv -----
// Testbench top for the cosine and sine unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module cosine_sine_unit_test;

	localparam logic OP_COS = 1'b0;
	localparam logic OP_SIN = 1'b1;

	// Angles in Q7.24 radians.
	localparam int QUARTER_TURN = 26353589;
	localparam int HALF_TURN = 52707179;
	localparam int FULL_TURN = 105414357;
	localparam int ANGLE_MAX = 32'h7FFFFFFF;
	localparam int ANGLE_MIN = 32'h80000000;

	localparam int WORDS_PER_PHASE = 475;
	localparam int SETTLE_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] angle = '0;
	logic operation = 1'b0;
	logic busy;
	logic signed [31:0] value;
	logic done;
	int errors;
	int pending;
	int quiet = 0;
	int idle_pct [4] = '{0, 60, 0, 36};

	cosine_sine_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.angle    (angle),
		.operation(operation),
		.value    (value),
		.done     (done)
	);

	cosine_sine_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.angle    (angle),
		.operation(operation),
		.value    (value),
		.done     (done),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hold the word until it is taken; idle first with the given odds.
	task automatic send_word(input logic [31:0] ang, input logic op, input int idle);
		while ($urandom_range(99) < idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		angle <= ang;
		operation <= op;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Pause the sender until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	function automatic logic [31:0] random_angle();
		int k;
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 4 * FULL_TURN) - 2 * FULL_TURN;
			2: begin
				// land near a multiple of pi/2, where folding and sign flips happen
				k = $urandom_range(0, 80) - 40;
				return k * QUARTER_TURN + $urandom_range(0, 64) - 32;
			end
			default: return $urandom_range(0, 511) - 256;
		endcase
	endfunction

	initial begin
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(32'd0, OP_COS, 0);
		send_word(32'd0, OP_SIN, 0);
		send_word(ANGLE_MAX, OP_COS, 0);
		send_word(ANGLE_MAX, OP_SIN, 0);
		send_word(ANGLE_MIN, OP_COS, 0);
		send_word(ANGLE_MIN, OP_SIN, 0);
		send_word(32'd1, OP_COS, 0);
		send_word(-32'sd1, OP_SIN, 0);
		send_word(QUARTER_TURN, OP_COS, 0);
		send_word(QUARTER_TURN, OP_SIN, 0);
		send_word(-QUARTER_TURN, OP_COS, 0);
		send_word(-QUARTER_TURN, OP_SIN, 0);
		send_word(QUARTER_TURN - 1, OP_COS, 0);
		send_word(QUARTER_TURN + 1, OP_COS, 0);
		send_word(HALF_TURN, OP_COS, 0);
		send_word(HALF_TURN, OP_SIN, 0);
		send_word(HALF_TURN + 1, OP_COS, 0);
		send_word(3 * QUARTER_TURN, OP_COS, 0);
		send_word(3 * QUARTER_TURN, OP_SIN, 0);
		send_word(FULL_TURN, OP_COS, 0);
		send_word(FULL_TURN, OP_SIN, 0);
		send_word(-FULL_TURN, OP_COS, 0);
		send_word(20 * FULL_TURN, OP_COS, 0);
		send_word(20 * FULL_TURN + QUARTER_TURN, OP_COS, 0);
		send_word(-20 * FULL_TURN, OP_SIN, 0);
		drain();

		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < WORDS_PER_PHASE; i++)
				send_word(random_angle(), 1'($urandom_range(1)), idle_pct[p]);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- cosine_sine_unit.f -----
rtl/csu_pkg.sv
rtl/csu_mul_q60.sv
rtl/csu_reduce.sv
rtl/csu_horner_step.sv
rtl/cosine_sine_unit.sv
test/cosine_sine_checker.sv
test/cosine_sine_unit_test.sv
